FILE: rtl/core/bdlpe_pkg.sv
// Package for the button debounce / long-press event block.
// Item types, per-button entry layout, event and state codes, register map.
// No dependencies.
package bdlpe_pkg;

    localparam int NUM_BUTTONS_DEFAULT = 8;

    // Event codes
    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_PRESSED  = 3'd1;
    localparam logic [2:0] EV_CLICK    = 3'd2;
    localparam logic [2:0] EV_RELEASED = 3'd3;
    localparam logic [2:0] EV_LONG     = 3'd4;

    // Button states
    localparam logic [1:0] ST_RELEASED = 2'd0;
    localparam logic [1:0] ST_PRESSED  = 2'd1;
    localparam logic [1:0] ST_LONG     = 2'd2;

    // Register map
    localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [1:0] REG_LONG_PRESS = 2'd1;
    localparam logic [1:0] REG_ENABLE     = 2'd2;

    localparam logic [15:0] DEBOUNCE_RESET   = 16'd50;
    localparam logic [15:0] LONG_PRESS_RESET = 16'd1000;
    localparam logic [7:0]  ENABLE_RESET     = 8'd0;

    typedef struct packed {
        logic [2:0]  button_index;
        logic        pin_level;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic [2:0] event_button;
        logic [2:0] event_code;
        logic [1:0] button_state;
        logic       last_of_run;
    } out_item_t;

    // One memory word per button
    typedef struct packed {
        logic        level;
        logic [1:0]  press_state;
        logic [31:0] last_change;
        logic [31:0] press_start;
        logic        long_seen;
    } entry_t;

    localparam entry_t ENTRY_RESET = '{
        level:       1'b0,
        press_state: ST_RELEASED,
        last_change: 32'd0,
        press_start: 32'd0,
        long_seen:   1'b0
    };

endpackage

FILE: rtl/core/button_debounce_long_press_events.sv
// An accepted item is registered in stage 1; its results then go to the output pair register.
// Throughput: one item per cycle for single-result items while out_stall is low;
//   two-result items (click + released, pressed + long press) hold the output for both.
// Read-modify-write of the per-button memory sets the pace; a write-forward
//   register covers back-to-back items on the same button.
// Reset (rst_n, async, low): registers to defaults, all button entries read as released.
module button_debounce_long_press_events #(
    parameter int NUM_BUTTONS = bdlpe_pkg::NUM_BUTTONS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // sample channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  bdlpe_pkg::in_item_t  in_data,
    // event channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output bdlpe_pkg::out_item_t out_data,
    // configuration write
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data
);
    import bdlpe_pkg::*;

    localparam int AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0] debounce_reg;
    logic [15:0] long_press_reg;
    logic [7:0]  enable_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= DEBOUNCE_RESET;
            long_press_reg <= LONG_PRESS_RESET;
            enable_reg     <= ENABLE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE:   debounce_reg   <= cfg_data;
                REG_LONG_PRESS: long_press_reg <= cfg_data;
                REG_ENABLE:     enable_reg     <= cfg_data[7:0];
                default:        ;  // unmapped index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake and stage control
    // ------------------------------------------------------------------
    logic     in_accept;
    logic     out_accept;
    logic     s1_fire;
    logic     s1_valid_reg;
    in_item_t s1_item_reg;
    entry_t   s1_rd_reg;

    logic       ob_valid_reg;
    logic       ob_pos_reg;     // 0: first result, 1: second
    logic       ob_two_reg;     // item gives two results
    logic [2:0] ob_ev0_reg;
    logic [2:0] ob_ev1_reg;
    logic [2:0] ob_button_reg;
    logic [1:0] ob_state_reg;
    logic       ob_last;

    assign ob_last    = !ob_two_reg || ob_pos_reg;
    assign out_valid  = ob_valid_reg;
    assign out_accept = out_valid && !out_stall;

    // Stage 1 may hand on when the output pair is empty or leaving this cycle
    assign s1_fire   = s1_valid_reg && (!ob_valid_reg || (out_accept && ob_last));
    assign in_stall  = s1_valid_reg && !s1_fire;
    assign in_accept = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // Per-button memory: read on accept; for an in-range, enabled button, written when stage 1 fires
    // ------------------------------------------------------------------
    entry_t mem [NUM_BUTTONS];

    logic [6:0]    in_idx_ext;
    logic [AW-1:0] in_addr;
    logic [6:0]    s1_idx_ext;
    logic [AW-1:0] s1_addr;

    assign in_idx_ext = {4'b0, in_data.button_index};
    assign in_addr    = in_idx_ext[AW-1:0];
    assign s1_idx_ext = {4'b0, s1_item_reg.button_index};
    assign s1_addr    = s1_idx_ext[AW-1:0];

    logic   wr_en;
    entry_t wr_entry;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_item_reg <= in_data;
            s1_rd_reg   <= mem[in_addr];
        end
        if (wr_en)
        begin
            mem[s1_addr] <= wr_entry;
        end
    end

    // Valid bits stand in for clearing the memory; last-write register forwards
    // the entry written at the edge the following item read.
    logic [NUM_BUTTONS-1:0] vld_reg;
    logic                   fwd_vld_reg;
    logic [AW-1:0]          fwd_addr_reg;
    entry_t                 fwd_entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            vld_reg      <= '0;
            fwd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (in_accept)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;
            if (wr_en)
            begin
                vld_reg[s1_addr] <= 1'b1;
                fwd_vld_reg      <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fwd_addr_reg  <= s1_addr;
            fwd_entry_reg <= wr_entry;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: debounce and event decision
    // ------------------------------------------------------------------
    logic        in_range;
    logic        enabled;
    entry_t      cur;
    logic        pressed;
    logic [31:0] now;
    logic [31:0] since_change;
    logic [31:0] since_press;
    logic        chg;
    logic [31:0] press_start_new;
    logic [2:0]  ev0;
    logic [2:0]  ev1;
    logic        two;
    logic [1:0]  st_new;

    assign in_range = s1_idx_ext < 7'(NUM_BUTTONS);
    assign enabled  = enable_reg[s1_item_reg.button_index];
    assign pressed  = !s1_item_reg.pin_level;
    assign now      = s1_item_reg.now_ms;

    always_comb
    begin
        if (fwd_vld_reg && fwd_addr_reg == s1_addr)
            cur = fwd_entry_reg;
        else if (vld_reg[s1_addr])
            cur = s1_rd_reg;
        else
            cur = ENTRY_RESET;
    end

    always_comb
    begin
        since_change    = now - cur.last_change;
        chg             = (pressed != cur.level) && (since_change >= {16'd0, debounce_reg});
        press_start_new = (chg && pressed) ? now : cur.press_start;
        since_press     = now - press_start_new;

        wr_entry             = cur;
        ev0                  = EV_NONE;
        ev1                  = EV_NONE;
        two                  = 1'b0;

        if (chg)
        begin
            wr_entry.level       = pressed;
            wr_entry.last_change = now;
            if (pressed)
            begin
                wr_entry.press_state = ST_PRESSED;
                wr_entry.press_start = now;
                wr_entry.long_seen   = 1'b0;
                ev0                  = EV_PRESSED;
            end
            else
            begin
                wr_entry.press_state = ST_RELEASED;
                if (!cur.long_seen)
                begin
                    ev0 = EV_CLICK;
                    ev1 = EV_RELEASED;
                    two = 1'b1;
                end
                else
                    ev0 = EV_RELEASED;
            end
        end

        // Long press: at most two events per item, so a release pair excludes it
        if (wr_entry.press_state == ST_PRESSED && !wr_entry.long_seen
            && since_press >= {16'd0, long_press_reg} && !two)
        begin
            wr_entry.long_seen   = 1'b1;
            wr_entry.press_state = ST_LONG;
            if (chg)
            begin
                ev1 = EV_LONG;
                two = 1'b1;
            end
            else
                ev0 = EV_LONG;
        end

        // Out-of-range and disabled buttons: state untouched, one empty event
        if (!in_range)
        begin
            ev0    = EV_NONE;
            two    = 1'b0;
            st_new = ST_RELEASED;
        end
        else if (!enabled)
        begin
            ev0    = EV_NONE;
            two    = 1'b0;
            st_new = cur.press_state;
        end
        else
            st_new = wr_entry.press_state;
    end

    assign wr_en = s1_fire && in_range && enabled;

    // ------------------------------------------------------------------
    // Output pair register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ob_valid_reg <= 1'b0;
            ob_pos_reg   <= 1'b0;
        end
        else if (s1_fire)
        begin
            ob_valid_reg <= 1'b1;
            ob_pos_reg   <= 1'b0;
        end
        else if (out_accept)
        begin
            if (ob_last)
                ob_valid_reg <= 1'b0;
            else
                ob_pos_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            ob_two_reg    <= two;
            ob_ev0_reg    <= ev0;
            ob_ev1_reg    <= ev1;
            ob_button_reg <= s1_item_reg.button_index;
            ob_state_reg  <= st_new;
        end
    end

    assign out_data.event_button = ob_button_reg;
    assign out_data.event_code   = ob_pos_reg ? ob_ev1_reg : ob_ev0_reg;
    assign out_data.button_state = ob_state_reg;
    assign out_data.last_of_run  = ob_last;

endmodule
